/* rtl/bmp2pal_pkg.sv */
// Shared types, constants and helper functions for the BMP to palette stream decoder.
package bmp2pal_pkg;

  // Default image limits
  localparam int unsigned MaxWidthDef  = 4096;
  localparam int unsigned MaxHeightDef = 4096;

  // Header layout (byte positions in the file)
  localparam logic [31:0] HdrBytes  = 32'd54;
  localparam logic [31:0] SigEnd    = 32'd2;
  localparam logic [31:0] SigLast   = 32'd13;
  localparam logic [31:0] OffFirst  = 32'd10;
  localparam logic [31:0] OffEnd    = 32'd14;
  localparam logic [31:0] WidFirst  = 32'd18;
  localparam logic [31:0] WidEnd    = 32'd22;
  localparam logic [31:0] HgtFirst  = 32'd22;
  localparam logic [31:0] HgtEnd    = 32'd26;
  localparam logic [31:0] BppFirst  = 32'd28;
  localparam logic [31:0] BppEnd    = 32'd30;

  localparam logic [15:0] SigBm     = 16'h4D42;
  localparam logic [15:0] Bpp24     = 16'd24;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_PIXEL  = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_e;

  // Error codes
  typedef enum logic [2:0] {
    ERR_SIGNATURE = 3'd0,
    ERR_DEPTH     = 3'd1,
    ERR_SIZE      = 3'd2,
    ERR_OFFSET    = 3'd3,
    ERR_TRUNCATED = 3'd4
  } err_e;

  // Parser phase, one-hot
  typedef enum logic [3:0] {
    PH_HEADER = 4'b0001,
    PH_SKIP   = 4'b0010,
    PH_PIXELS = 4'b0100,
    PH_DONE   = 4'b1000
  } phase_e;

  // One color channel divided by 43 (0..5)
  function automatic logic [2:0] div43(input logic [7:0] b);
    logic [2:0] q;
    q = 3'd0;
    if (b >= 8'd43)  q = 3'd1;
    if (b >= 8'd86)  q = 3'd2;
    if (b >= 8'd129) q = 3'd3;
    if (b >= 8'd172) q = 3'd4;
    if (b >= 8'd215) q = 3'd5;
    return q;
  endfunction

  // 216-color cube index: 16 + r*36 + g*6 + b
  function automatic logic [7:0] cube_color(input logic [2:0] qr, input logic [2:0] qg,
                                            input logic [2:0] qb);
    return 8'd16 + 8'(qr) * 8'd36 + 8'(qg) * 8'd6 + 8'(qb);
  endfunction

endpackage

/* rtl/bmp24_to_palette216_stream.sv */
// Streaming 24-bit BMP parser that maps each pixel to a 216-color palette index.
// Timing: a result is registered and shown in the cycle after the byte that causes it.
// Throughput: one byte per cycle; input stalls only while a held result is not
//   taken by the sink (single output register, single state-update stage).
// Reset: parser returns to the header phase with all fields cleared; no result held.
module bmp24_to_palette216_stream #(
  parameter int unsigned MAX_WIDTH  = bmp2pal_pkg::MaxWidthDef,
  parameter int unsigned MAX_HEIGHT = bmp2pal_pkg::MaxHeightDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input byte stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] file_byte
  input  logic [1:0]  s_axis_tuser_i,   // [0] start_of_file, [1] end_of_file
  // Result stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [63:0] m_axis_tdata_o,   // [7:0] color, [31:8] pixel_index,
                                        // [44:32] image_width, [57:45] image_height,
                                        // [60:58] error_code, [63:61] zero
  output logic [1:0]  m_axis_tuser_o,   // [1:0] kind
  output logic        m_axis_tlast_o    // last
);
  import bmp2pal_pkg::*;

  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned PW = (HW + WW > 24) ? HW + WW : 24;

  // Parser state
  phase_e        phase_q, phase_d;
  logic [31:0]   pos_q, pos_d;
  logic [15:0]   sig_q, sig_d;
  logic [31:0]   offset_q, offset_d;
  logic [31:0]   raw_w_q, raw_w_d;
  logic [31:0]   raw_h_q, raw_h_d;
  logic [15:0]   depth_q, depth_d;
  logic [WW-1:0] col_q, col_d;
  logic [HW-1:0] row_q, row_d;
  logic [1:0]    bip_q, bip_d;
  logic [2:0]    qb_q, qb_d;
  logic [2:0]    qg_q, qg_d;
  logic [1:0]    pad_q, pad_d;
  logic [23:0]   base_q, base_d;

  // Header-derived values, settled long before the last header byte
  logic [31:0]   habs_q;
  logic          size_bad_q;
  logic [PW-1:0] prod_q;
  logic [WW-1:0] wid;
  logic [HW-1:0] hgt;

  // Result of the current request
  logic          res_valid;
  kind_e         res_kind;
  logic [7:0]    res_color;
  logic [23:0]   res_index;
  logic [12:0]   res_w;
  logic [12:0]   res_h;
  err_e          res_err;
  logic          res_last;

  // Output register
  logic          out_valid_q;
  logic [63:0]   out_data_q;
  logic [1:0]    out_kind_q;
  logic          out_last_q;

  logic          s_acc;
  logic          sof;
  logic          eof;
  logic [7:0]    b;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign s_acc           = s_axis_tvalid_i && s_axis_tready_o;
  assign sof             = s_axis_tuser_i[0];
  assign eof             = s_axis_tuser_i[1];
  assign b               = s_axis_tdata_i;
  assign wid             = raw_w_q[WW-1:0];
  assign hgt             = habs_q[HW-1:0];

  // Size checks and first row base, from stored header fields
  always_ff @(posedge clk_i) begin
    habs_q     <= raw_h_q[31] ? (32'd0 - raw_h_q) : raw_h_q;
    size_bad_q <= raw_w_q[31] || (raw_w_q > 32'(MAX_WIDTH)) || (habs_q > 32'(MAX_HEIGHT));
    prod_q     <= PW'(HW'(hgt - HW'(1))) * PW'(wid);
  end

  // Parser next state and result
  always_comb begin
    logic [31:0]   p;
    logic [1:0]    lane;
    logic [WW-1:0] col_inc;
    logic [HW-1:0] row_inc;
    phase_e        cur;

    phase_d  = phase_q;  pos_d  = pos_q;  sig_d   = sig_q;   offset_d = offset_q;
    raw_w_d  = raw_w_q;  raw_h_d = raw_h_q; depth_d = depth_q;
    col_d    = col_q;    row_d  = row_q;  bip_d   = bip_q;   qb_d     = qb_q;
    qg_d     = qg_q;     pad_d  = pad_q;  base_d  = base_q;

    res_valid = 1'b0;     res_kind = KIND_HEADER; res_color = 8'd0; res_index = 24'd0;
    res_w     = 13'd0;    res_h    = 13'd0;       res_err   = ERR_SIGNATURE;
    res_last  = 1'b0;

    col_inc = col_q + WW'(1);
    row_inc = row_q + HW'(1);
    p       = sof ? 32'd0 : pos_q;
    lane    = p[1:0] - 2'd2;
    cur     = sof ? PH_HEADER : phase_q;

    if (s_acc) begin
      // New file: clear the parser
      if (sof) begin
        phase_d = PH_HEADER; pos_d = 32'd0; sig_d = 16'd0; offset_d = 32'd0;
        raw_w_d = 32'd0; raw_h_d = 32'd0; depth_d = 16'd0;
        col_d = '0; row_d = '0; bip_d = 2'd0; qb_d = 3'd0; qg_d = 3'd0;
        pad_d = 2'd0; base_d = 24'd0;
      end

      if (cur != PH_DONE) begin
        if (eof) begin
          // Early end of file
          phase_d   = PH_DONE;
          res_valid = 1'b1;
          res_kind  = KIND_ERROR;
          res_err   = ERR_TRUNCATED;
          res_last  = 1'b1;
        end else begin
          case (cur)
            PH_HEADER: begin
              // Field capture, little-endian
              if (p < SigEnd) begin
                sig_d[8*p[0] +: 8] = b;
              end else if (p inside {[OffFirst:OffEnd - 32'd1]}) begin
                offset_d[8*lane +: 8] = b;
              end else if (p inside {[WidFirst:WidEnd - 32'd1]}) begin
                raw_w_d[8*lane +: 8] = b;
              end else if (p inside {[HgtFirst:HgtEnd - 32'd1]}) begin
                raw_h_d[8*lane +: 8] = b;
              end else if (p inside {[BppFirst:BppEnd - 32'd1]}) begin
                depth_d[8*p[0] +: 8] = b;
              end
              pos_d = p + 32'd1;

              if (p == SigLast && sig_q != SigBm) begin
                phase_d   = PH_DONE;
                res_valid = 1'b1;
                res_kind  = KIND_ERROR;
                res_err   = ERR_SIGNATURE;
                res_last  = 1'b1;
              end else if (p == HdrBytes - 32'd1) begin
                // Header checks in order: depth, size, offset
                res_valid = 1'b1;
                if (depth_q != Bpp24) begin
                  phase_d  = PH_DONE;
                  res_kind = KIND_ERROR;
                  res_err  = ERR_DEPTH;
                  res_last = 1'b1;
                end else if (size_bad_q) begin
                  phase_d  = PH_DONE;
                  res_kind = KIND_ERROR;
                  res_err  = ERR_SIZE;
                  res_last = 1'b1;
                end else if (offset_q < HdrBytes) begin
                  phase_d  = PH_DONE;
                  res_kind = KIND_ERROR;
                  res_err  = ERR_OFFSET;
                  res_last = 1'b1;
                end else begin
                  res_kind = KIND_HEADER;
                  res_w    = raw_w_q[12:0];
                  res_h    = habs_q[12:0];
                  if (wid == '0 || hgt == '0) begin
                    // Empty image
                    phase_d  = PH_DONE;
                    res_last = 1'b1;
                  end else begin
                    row_d   = '0;
                    col_d   = '0;
                    bip_d   = 2'd0;
                    pad_d   = 2'd0;
                    base_d  = raw_h_q[31] ? 24'd0 : prod_q[23:0];
                    phase_d = (offset_q == HdrBytes) ? PH_PIXELS : PH_SKIP;
                  end
                end
              end
            end

            PH_SKIP: begin
              // Skip up to the pixel-data offset
              pos_d = pos_q + 32'd1;
              if (pos_d >= offset_q) begin
                phase_d = PH_PIXELS;
              end
            end

            PH_PIXELS: begin
              if (pad_q != 2'd0) begin
                pad_d = pad_q - 2'd1;
              end else if (bip_q == 2'd0) begin
                qb_d  = div43(b);
                bip_d = 2'd1;
              end else if (bip_q == 2'd1) begin
                qg_d  = div43(b);
                bip_d = 2'd2;
              end else begin
                // Red byte completes the pixel
                bip_d     = 2'd0;
                res_valid = 1'b1;
                res_kind  = KIND_PIXEL;
                res_color = cube_color(div43(b), qg_q, qb_q);
                res_index = base_q + 24'(col_q);
                if (col_inc == wid) begin
                  col_d = '0;
                  row_d = row_inc;
                  if (row_inc == hgt) begin
                    res_last = 1'b1;
                    phase_d  = PH_DONE;
                  end else begin
                    // Row padding to a 4-byte multiple equals width mod 4
                    pad_d  = raw_w_q[1:0];
                    base_d = raw_h_q[31] ? (base_q + 24'(wid)) : (base_q - 24'(wid));
                  end
                end else begin
                  col_d = col_inc;
                end
              end
            end

            default: begin
              phase_d = phase_q;
            end
          endcase
        end
      end
    end
  end

  // Parser registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER; pos_q <= 32'd0; sig_q <= 16'd0; offset_q <= 32'd0;
      raw_w_q <= 32'd0; raw_h_q <= 32'd0; depth_q <= 16'd0;
      col_q <= '0; row_q <= '0; bip_q <= 2'd0; qb_q <= 3'd0; qg_q <= 3'd0;
      pad_q <= 2'd0; base_q <= 24'd0;
    end else begin
      phase_q <= phase_d; pos_q <= pos_d; sig_q <= sig_d; offset_q <= offset_d;
      raw_w_q <= raw_w_d; raw_h_q <= raw_h_d; depth_q <= depth_d;
      col_q <= col_d; row_q <= row_d; bip_q <= bip_d; qb_q <= qb_d; qg_q <= qg_d;
      pad_q <= pad_d; base_q <= base_d;
    end
  end

  // Output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_acc) begin
      out_valid_q <= res_valid;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (s_acc && res_valid) begin
      out_data_q <= {3'd0, res_err, res_h, res_w, res_index, res_color};
      out_kind_q <= res_kind;
      out_last_q <= res_last;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_kind_q;
  assign m_axis_tlast_o  = out_last_q;

`ifndef SYNTHESIS
  // A finished file produces nothing until a new file starts
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_acc && phase_q == PH_DONE && !sof) |-> !res_valid)
    else $error("result produced after file end");

  // Errors always close the file
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o == KIND_ERROR) |-> m_axis_tlast_o)
    else $error("error result without last");

  // Pixel colors stay inside the color cube
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o == KIND_PIXEL) |->
      (m_axis_tdata_o[7:0] >= 8'd16 && m_axis_tdata_o[7:0] <= 8'd231))
    else $error("pixel color out of range");

  // A non-final header result moves the parser on to skip or pixel data
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_acc && res_valid && res_kind == KIND_HEADER && !res_last) |=>
      (phase_q == PH_SKIP || phase_q == PH_PIXELS))
    else $error("header accepted but parser did not advance");
`endif

endmodule
